// ===== rtl/wml_pkg.sv =====
// Shared constants, types and the fixed-point interpolation helper for the wavetable lookup.
`default_nettype none

package wml_pkg;

    localparam int TABLE_SIZE_DEF = 2048;
    localparam int MAX_FRAMES_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int NF_W     = 7;

    localparam logic [NF_W-1:0] NUM_FRAMES_RESET = 7'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [FRAC_W-1:0]          frac_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // a + floor(f * (b - a) / 2^16); the result stays between a and b
    function automatic sample_t lerp16(sample_t a, sample_t b, frac_t f);
        logic signed [SAMPLE_W:0]          d;
        logic signed [SAMPLE_W+FRAC_W+1:0] m;
        logic signed [SAMPLE_W+FRAC_W+1:0] sh;
        d  = (SAMPLE_W+1)'(b) - (SAMPLE_W+1)'(a);
        m  = (SAMPLE_W+FRAC_W+2)'(d) * (SAMPLE_W+FRAC_W+2)'($signed({1'b0, f}));
        sh = m >>> FRAC_W;
        return a + SAMPLE_W'(sh);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wml_table.sv =====
// Single-port wavetable sample memory with registered read data.
`default_nettype none

module wml_table #(
    parameter int DEPTH  = wml_pkg::TABLE_SIZE_DEF * wml_pkg::MAX_FRAMES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    addr,
    input  wire wml_pkg::sample_t     wdata,
    output wml_pkg::sample_t          rdata
);

    wml_pkg::sample_t mem [DEPTH];
    wml_pkg::sample_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/wavetable_morph_lookup_core.sv =====
// Top level of the multi-frame wavetable lookup with index interpolation and frame morphing.
//
// A write beat stores one sample; a read beat makes four table reads (two neighbors in each of
// two frames) one after another through the single port of the table memory, and the next beat
// is taken once the last of them issues. Reads run as a pipeline: memory read, index
// interpolation, frame interpolation, output register. While a result waits in the output
// register the pipeline stalls, and a new beat is taken only if the issue stage is empty. The
// table holds no defined contents after reset and needs no clearing; num_frames resets to 1, and
// values of 0 or above MAX_FRAMES act as 1 and MAX_FRAMES. Writes outside the table are dropped.
`default_nettype none

module wavetable_morph_lookup_core #(
    parameter int TABLE_SIZE = wml_pkg::TABLE_SIZE_DEF,
    parameter int MAX_FRAMES = wml_pkg::MAX_FRAMES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // write_frame[5:0], write_index[16:6], write_value[32:17], phase[64:33],
    // frame_position[86:65], zero fill[87]
    input  wire logic [87:0] s_tdata,
    // operation[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // sample[15:0]
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);

    localparam int DEPTH   = TABLE_SIZE * MAX_FRAMES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PROD_W  = 49;
    localparam logic [ADDR_W-1:0] TS_A = ADDR_W'(TABLE_SIZE);

    // beat fields
    logic [5:0]         in_frame;
    logic [10:0]        in_index;
    wml_pkg::sample_t   in_value;
    logic [31:0]        in_phase;
    logic [21:0]        in_fpos;
    wml_pkg::op_t       in_op;

    assign in_frame = s_tdata[5:0];
    assign in_index = s_tdata[16:6];
    assign in_value = s_tdata[32:17];
    assign in_phase = s_tdata[64:33];
    assign in_fpos  = s_tdata[86:65];
    assign in_op    = wml_pkg::op_t'(s_tuser[0]);

    // configuration
    logic [wml_pkg::NF_W-1:0] num_frames_reg;
    logic [FRAME_W-1:0]       last_frame;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (num_frames_reg == '0) begin
            last_frame = '0;
        end else if (32'(num_frames_reg) > MAX_FRAMES) begin
            last_frame = FRAME_W'(MAX_FRAMES - 1);
        end else begin
            last_frame = FRAME_W'(num_frames_reg - 7'd1);
        end
    end

    // decode at accept
    logic [PROD_W-1:0]   prod;
    logic [IDX_W-1:0]    dec_idx1;
    logic [IDX_W-1:0]    dec_idx2;
    logic [FRAME_W-1:0]  dec_f1;
    logic [FRAME_W-1:0]  dec_f2;
    wml_pkg::frac_t      dec_ffrac;
    logic                dec_wr_ok;
    logic [ADDR_W-1:0]   dec_wr_addr;

    always_comb begin
        prod     = PROD_W'(in_phase) * PROD_W'(TABLE_SIZE);
        dec_idx1 = prod[32 +: IDX_W];
        dec_idx2 = (dec_idx1 == IDX_W'(TABLE_SIZE - 1)) ? '0 : IDX_W'(dec_idx1 + 1'b1);
        if (32'(in_fpos[21:16]) >= 32'(last_frame)) begin
            dec_f1    = last_frame;
            dec_f2    = last_frame;
            dec_ffrac = '0;
        end else begin
            dec_f1    = FRAME_W'(in_fpos[21:16]);
            dec_f2    = FRAME_W'(32'(in_fpos[21:16]) + 1);
            dec_ffrac = in_fpos[15:0];
        end
        dec_wr_ok   = (32'(in_frame) < MAX_FRAMES) && (32'(in_index) < TABLE_SIZE);
        dec_wr_addr = ADDR_W'(in_frame) * TS_A + ADDR_W'(in_index);
    end

    // issue stage
    logic                cur_valid_reg;
    logic                cur_valid_next;
    logic [1:0]          step_reg;
    wml_pkg::op_t        cur_op_reg;
    logic                cur_wr_ok_reg;
    logic [ADDR_W-1:0]   cur_wr_addr_reg;
    wml_pkg::sample_t    cur_value_reg;
    logic [IDX_W-1:0]    cur_idx1_reg;
    logic [IDX_W-1:0]    cur_idx2_reg;
    wml_pkg::frac_t      cur_ifrac_reg;
    logic [FRAME_W-1:0]  cur_f1_reg;
    logic [FRAME_W-1:0]  cur_f2_reg;
    wml_pkg::frac_t      cur_ffrac_reg;

    logic                adv;
    logic                done;
    logic                accept;
    logic                mem_en;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [FRAME_W-1:0]  rd_frame;
    logic [IDX_W-1:0]    rd_idx;
    wml_pkg::sample_t    mem_rdata;

    assign adv      = !m_tvalid || m_tready;
    assign done     = cur_valid_reg && adv
                      && (cur_op_reg == wml_pkg::OP_WRITE || step_reg == 2'd3);
    assign s_tready = !cur_valid_reg || done;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        if (accept) begin
            cur_valid_next = 1'b1;
        end else if (done) begin
            cur_valid_next = 1'b0;
        end
    end

    assign rd_frame = step_reg[1] ? cur_f2_reg : cur_f1_reg;
    assign rd_idx   = step_reg[0] ? cur_idx2_reg : cur_idx1_reg;
    assign mem_we   = (cur_op_reg == wml_pkg::OP_WRITE);
    assign mem_en   = cur_valid_reg && adv && (!mem_we || cur_wr_ok_reg);
    assign mem_addr = mem_we ? cur_wr_addr_reg
                             : ADDR_W'(rd_frame) * TS_A + ADDR_W'(rd_idx);

    wml_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (cur_value_reg),
        .rdata (mem_rdata)
    );

    // read pipeline
    logic                rd_valid_reg;
    logic [1:0]          rd_step_reg;
    wml_pkg::frac_t      rd_ifrac_reg;
    wml_pkg::frac_t      rd_ffrac_reg;
    wml_pkg::sample_t    a_reg;
    wml_pkg::sample_t    s1_reg;
    wml_pkg::sample_t    s2_reg;
    wml_pkg::frac_t      fin_ffrac_reg;
    logic                fin_valid_reg;
    logic                m_tvalid_reg;
    wml_pkg::sample_t    m_sample_reg;
    wml_pkg::sample_t    ix_lerp;

    assign ix_lerp = wml_pkg::lerp16(a_reg, mem_rdata, rd_ifrac_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_frames_reg <= wml_pkg::NUM_FRAMES_RESET;
            cur_valid_reg  <= 1'b0;
            step_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            fin_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_frames_reg <= cfg_data;
            end
            cur_valid_reg <= cur_valid_next;
            if (cur_valid_reg && adv && cur_op_reg == wml_pkg::OP_READ) begin
                step_reg <= step_reg + 2'd1;
            end
            if (adv) begin
                rd_valid_reg  <= cur_valid_reg && cur_op_reg == wml_pkg::OP_READ;
                fin_valid_reg <= rd_valid_reg && rd_step_reg == 2'd3;
                m_tvalid_reg  <= fin_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_op_reg      <= in_op;
            cur_wr_ok_reg   <= dec_wr_ok;
            cur_wr_addr_reg <= dec_wr_addr;
            cur_value_reg   <= in_value;
            cur_idx1_reg    <= dec_idx1;
            cur_idx2_reg    <= dec_idx2;
            cur_ifrac_reg   <= prod[31:16];
            cur_f1_reg      <= dec_f1;
            cur_f2_reg      <= dec_f2;
            cur_ffrac_reg   <= dec_ffrac;
        end
        if (adv) begin
            rd_step_reg  <= step_reg;
            rd_ifrac_reg <= cur_ifrac_reg;
            rd_ffrac_reg <= cur_ffrac_reg;
            if (rd_valid_reg) begin
                case (rd_step_reg)
                    2'd0, 2'd2: begin
                        a_reg <= mem_rdata;
                    end
                    2'd1: begin
                        s1_reg <= ix_lerp;
                    end
                    default: begin
                        s2_reg        <= ix_lerp;
                        fin_ffrac_reg <= rd_ffrac_reg;
                    end
                endcase
            end
            if (fin_valid_reg) begin
                m_sample_reg <= wml_pkg::lerp16(s1_reg, s2_reg, fin_ffrac_reg);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sample_reg;

endmodule

`default_nettype wire

// ===== tb/sv/wavetable_morph_lookup_core_tb.sv =====
// Self-checking testbench for the wavetable morph lookup core: directed table, then random beats.
`timescale 1ns / 100ps

module wavetable_morph_lookup_core_tb;

    localparam int TBL_SIZE       = wml_pkg::TABLE_SIZE_DEF;
    localparam int FRAMES_MAX     = wml_pkg::MAX_FRAMES_DEF;
    localparam int STORE_DEPTH    = TBL_SIZE * FRAMES_MAX;
    localparam int HOT_N          = 16;
    localparam int DIR_N          = 26;
    localparam int SEG_N          = 9;
    localparam int SEG_BEATS      = 210;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 12;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_READ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [5:0]  frame;
        logic [10:0] index;
        logic [15:0] value;
        logic [31:0] phase;
        logic [21:0] fpos;
        logic        typed;
        logic [15:0] sample;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;

    wavetable_morph_lookup_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // mirror of the table and the frame count
    wml_pkg::sample_t wave_mem     [0:STORE_DEPTH-1];
    bit               wave_written [0:STORE_DEPTH-1];
    logic [6:0]       num_frames_reg = wml_pkg::NUM_FRAMES_RESET;

    wml_pkg::sample_t sample_expected_q[$];
    wml_pkg::sample_t sample_head;

    int tx_idle_pct   = 36;
    int rx_idle_pct   = 80;
    int hold_requests = 0;
    int hold_served   = 0;
    int rx_hold_left  = 0;

    int beats_sent     = 0;
    int reads_sent     = 0;
    int writes_sent    = 0;
    int cfg_writes     = 0;
    int results_seen   = 0;
    int mismatches     = 0;

    int hot_idx [HOT_N];

    stim_row_t dir_rows [DIR_N] = '{
        '{ROW_WRITE, 6'd0,  11'd0,    16'h7FFF, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd0,  11'd1,    16'h8000, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0000_0000, 22'h00_0000, 1'b1, 16'h7FFF},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h001F_FFFF, 22'h3F_FFFF, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd0,  11'd2047, 16'h0000, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'hFFE0_0000, 22'h00_0000, 1'b1, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'hFFFF_FFFF, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd1,  11'd0,    16'h8000, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd1,  11'd1,    16'h0064, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd63, 11'd0,    16'hFFFF, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd63, 11'd1,    16'h0005, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_CFG,   6'd0,  11'd0,    16'd0,    32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0000_0000, 22'h01_0000, 1'b1, 16'h7FFF},
        '{ROW_CFG,   6'd0,  11'd0,    16'd2,    32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0000_0000, 22'h00_8000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0000_0000, 22'h3F_FFFF, 1'b1, 16'h8000},
        '{ROW_CFG,   6'd0,  11'd0,    16'd127,  32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0000_0000, 22'h3F_FFFF, 1'b1, 16'hFFFF},
        '{ROW_WRITE, 6'd62, 11'd0,    16'h7FFF, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_WRITE, 6'd62, 11'd1,    16'h7FFF, 32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0010_0000, 22'h3E_8000, 1'b0, 16'h0000},
        '{ROW_CFG,   6'd0,  11'd0,    16'd64,   32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h0000_0000, 22'h3F_0000, 1'b1, 16'hFFFF},
        '{ROW_CFG,   6'd0,  11'd0,    16'd65,   32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000},
        '{ROW_READ,  6'd0,  11'd0,    16'h0000, 32'h001F_FFFF, 22'h3F_FFFF, 1'b0, 16'h0000},
        '{ROW_CFG,   6'd0,  11'd0,    16'd1,    32'h0000_0000, 22'h00_0000, 1'b0, 16'h0000}
    };

    logic [6:0] nf_plan [SEG_N] = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd5, 7'd33, 7'd1, 7'd100, 7'd17};

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int eff_frames();
        int n;
        n = num_frames_reg;
        if (n < 1) n = 1;
        if (n > FRAMES_MAX) n = FRAMES_MAX;
        return n;
    endfunction

    // a + floor(f * (b - a) / 2^16)
    function automatic wml_pkg::sample_t blend(wml_pkg::sample_t a, wml_pkg::sample_t b,
                                               wml_pkg::frac_t f);
        longint d;
        longint m;
        d = longint'(b) - longint'(a);
        m = d * longint'(f);
        return wml_pkg::sample_t'(longint'(a) + (m >>> wml_pkg::FRAC_W));
    endfunction

    function automatic void morph_split(input logic [21:0] fpos, output int f1, output int f2,
                                        output wml_pkg::frac_t ffrac);
        int          nf;
        logic [21:0] top;
        logic [21:0] pos;
        nf    = eff_frames();
        top   = 22'((nf - 1) << wml_pkg::FRAC_W);
        pos   = (fpos > top) ? top : fpos;
        f1    = pos[21:16];
        f2    = (f1 + 1 > nf - 1) ? nf - 1 : f1 + 1;
        ffrac = pos[15:0];
    endfunction

    function automatic wml_pkg::sample_t frame_interp(int frame, int idx, wml_pkg::frac_t f);
        int nxt;
        nxt = (idx + 1) % TBL_SIZE;
        return blend(wave_mem[frame * TBL_SIZE + idx], wave_mem[frame * TBL_SIZE + nxt], f);
    endfunction

    function automatic wml_pkg::sample_t predict_sample(logic [31:0] phase, logic [21:0] fpos);
        int             f1;
        int             f2;
        int             idx;
        wml_pkg::frac_t ifrac;
        wml_pkg::frac_t ffrac;
        idx   = phase[31:21];
        ifrac = phase[20:5];
        morph_split(fpos, f1, f2, ffrac);
        return blend(frame_interp(f1, idx, ifrac), frame_interp(f2, idx, ifrac), ffrac);
    endfunction

    function automatic wml_pkg::sample_t rand_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4) return 16'sh8000;
        if (sel < 8) return 16'sh7FFF;
        if (sel < 11) return 16'sh0000;
        if (sel < 15) return 16'shFFFF;
        return wml_pkg::sample_t'($urandom);
    endfunction

    task automatic send_beat(input wml_pkg::op_t op, input logic [5:0] wf, input logic [10:0] wi,
                             input wml_pkg::sample_t wv, input logic [31:0] ph,
                             input logic [21:0] fp, input bit typed,
                             input wml_pkg::sample_t typed_val);
        int addr;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, fp, ph, wv, wi, wf};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (op == wml_pkg::OP_WRITE) begin
            addr = int'({wf, wi});
            wave_mem[addr]     = wv;
            wave_written[addr] = 1'b1;
            writes_sent++;
        end else begin
            sample_expected_q.push_back(typed ? typed_val : predict_sample(ph, fp));
            reads_sent++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sample_expected_q.size() != 0);
    endtask

    task automatic write_num_frames(input logic [6:0] v);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        num_frames_reg = v;
        cfg_writes++;
    endtask

    task automatic fill_entry(input int frame, input int idx);
        if (!wave_written[frame * TBL_SIZE + idx])
            send_beat(wml_pkg::OP_WRITE, 6'(frame), 11'(idx), rand_sample(), $urandom,
                      22'($urandom), 1'b0, '0);
    endtask

    // writes whatever neighbors are still empty, then issues the lookup
    task automatic morph_read_with_fill();
        int             nf;
        int             sel;
        int             idx;
        int             nxt;
        int             f1;
        int             f2;
        wml_pkg::frac_t ffrac;
        logic [21:0]    fpos;
        logic [31:0]    ph;
        nf  = eff_frames();
        sel = $urandom_range(99);
        if (sel < 70)
            fpos = 22'($urandom_range((nf - 1) << wml_pkg::FRAC_W));
        else if (sel < 85)
            fpos = 22'($urandom);
        else
            fpos = {6'($urandom_range(nf - 1)), 16'h0000};
        idx = ($urandom_range(99) < 60) ? hot_idx[$urandom_range(HOT_N - 1)]
                                        : $urandom_range(TBL_SIZE - 1);
        ph  = {11'(idx), 21'($urandom)};
        nxt = (idx + 1) % TBL_SIZE;
        morph_split(fpos, f1, f2, ffrac);
        fill_entry(f1, idx);
        fill_entry(f1, nxt);
        fill_entry(f2, idx);
        fill_entry(f2, nxt);
        send_beat(wml_pkg::OP_READ, 6'($urandom), 11'($urandom), wml_pkg::sample_t'($urandom),
                  ph, fpos, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served  = hold_requests;
            rx_hold_left = RX_HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_expected_q.size() == 0) begin
                $error("sample: no beat expected, actual %0d", $signed(m_tdata));
                mismatches++;
            end else begin
                sample_head = sample_expected_q.pop_front();
                results_seen++;
                if (m_tdata !== sample_head) begin
                    $error("sample: expected %0d actual %0d", sample_head, $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int  seg_start;
        bit  paused;
        stim_row_t row;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            wave_mem[i]     = '0;
            wave_written[i] = 1'b0;
        end
        hot_idx[0] = 0;
        hot_idx[1] = 1;
        hot_idx[2] = TBL_SIZE - 1;
        hot_idx[3] = TBL_SIZE - 2;
        hot_idx[4] = TBL_SIZE / 2 - 1;
        hot_idx[5] = TBL_SIZE / 2;
        for (int i = 6; i < HOT_N; i++) hot_idx[i] = $urandom_range(TBL_SIZE - 1);
        paused = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG: begin
                    write_num_frames(row.value[6:0]);
                end
                ROW_WRITE: begin
                    send_beat(wml_pkg::OP_WRITE, row.frame, row.index, row.value, row.phase,
                              row.fpos, 1'b0, '0);
                end
                default: begin
                    send_beat(wml_pkg::OP_READ, row.frame, row.index, row.value, row.phase,
                              row.fpos, row.typed, row.sample);
                end
            endcase
        end

        for (int seg = 0; seg < SEG_N; seg++) begin
            if (seg < 3) begin
                tx_idle_pct = 36;
                rx_idle_pct = 80;
            end else if (seg < 6) begin
                tx_idle_pct = 80;
                rx_idle_pct = 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_num_frames(nf_plan[seg]);
            // long receiver stall while the sender keeps pushing
            if (seg == 6) hold_requests++;
            seg_start = beats_sent;
            while (beats_sent - seg_start < SEG_BEATS) begin
                if (seg == 4 && !paused && beats_sent - seg_start >= SEG_BEATS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 10)
                    send_beat(wml_pkg::OP_WRITE, 6'($urandom), 11'($urandom), rand_sample(),
                              $urandom, 22'($urandom), 1'b0, '0);
                else
                    morph_read_with_fill();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        $display("Run covered %0d beats: %0d lookups, %0d table writes, %0d frame-count writes.",
                 beats_sent, reads_sent, writes_sent, cfg_writes);
        $display("%0d samples compared, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && sample_expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== wavetable_morph_lookup_core.f =====
rtl/wml_pkg.sv
rtl/wml_table.sv
rtl/wavetable_morph_lookup_core.sv
tb/sv/wavetable_morph_lookup_core_tb.sv
